// File: hdl/ptq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ptq_pkg;

    // Operation codes carried by the kind field of a command word
    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_POP    = 2'd1,
        OP_PURGE  = 2'd2,
        OP_FLUSH  = 2'd3
    } op_t;

    // Result status codes
    typedef enum logic [1:0] {
        STAT_INSERTED = 2'd0,
        STAT_FULL     = 2'd1,
        STAT_EMPTY    = 2'd2,
        STAT_REMOVED  = 2'd3
    } status_t;

    // One stored queue entry
    typedef struct packed {
        logic [7:0]  kind;
        logic [7:0]  prio;
        logic [15:0] tag;
    } entry_t;

    // Command word
    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] task_tag;
        logic [7:0]  task_priority;
        logic [7:0]  task_kind;
    } in_word_t;

    // Result word
    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] out_tag;
        logic [7:0]  out_priority;
        logic [7:0]  out_kind;
        logic        last_of_run;
        logic [4:0]  occupancy;
    } out_word_t;

    // Occupancy field keeps the low five bits of the count
    function automatic logic [4:0] occ_bits(input logic [31:0] value);
        return value[4:0];
    endfunction

endpackage

`default_nettype wire

// File: hdl/ptq_stream_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface ptq_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: hdl/ptq_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module ptq_mem #(
    parameter int QUEUE_DEPTH = 16,
    parameter int IW          = 4
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [IW-1:0]    wr_addr,
    input  wire ptq_pkg::entry_t  wr_data,
    input  wire logic             rd_en,
    input  wire logic [IW-1:0]    rd_addr,
    output ptq_pkg::entry_t       rd_data
);

    ptq_pkg::entry_t mem_reg [QUEUE_DEPTH];
    ptq_pkg::entry_t rd_data_reg;

    // Write one entry
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read, held while no read is issued
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

// File: hdl/ptq_seq.sv
`timescale 1ns / 1ps
`default_nettype none

module ptq_seq #(
    parameter int QUEUE_DEPTH = 16,
    parameter int IW          = 4,
    parameter int CW          = 5
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire ptq_pkg::in_word_t in_word,
    output logic                 emit_valid,
    output ptq_pkg::out_word_t   emit_word,
    input  wire logic            emit_free,
    output logic                 rd_en,
    output logic [IW-1:0]        rd_addr,
    input  wire ptq_pkg::entry_t rd_data,
    output logic                 wr_en,
    output logic [IW-1:0]        wr_addr,
    output ptq_pkg::entry_t      wr_data
);

    localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_RUN  = 3'b010,
        ST_FIN  = 3'b100
    } state_t;

    state_t                  state_reg, state_next;
    ptq_pkg::op_t            op_reg, op_next;
    ptq_pkg::in_word_t       req_reg, req_next;
    logic [CW-1:0]           count_reg, count_next;
    logic [IW-1:0]           rd_idx_reg, rd_idx_next;
    logic [CW-1:0]           rd_left_reg, rd_left_next;
    logic                    b_vld_reg, b_vld_next;
    logic [IW-1:0]           b_idx_reg, b_idx_next;
    logic [CW-1:0]           pos_reg, pos_next;
    logic [CW-1:0]           removed_reg, removed_next;
    ptq_pkg::entry_t         res_reg, res_next;
    ptq_pkg::status_t        res_status_reg, res_status_next;
    logic [4:0]              res_occ_reg, res_occ_next;

    ptq_pkg::entry_t         new_entry;
    logic                    match;
    logic                    stall;
    logic                    stop;
    logic [CW-1:0]           count_m1;
    logic [CW-1:0]           count_p1;
    logic [CW-1:0]           purge_left;

    assign new_entry.kind = req_reg.task_kind;
    assign new_entry.prio = req_reg.task_priority;
    assign new_entry.tag  = req_reg.task_tag;
    assign match          = (rd_data.kind == req_reg.task_kind);
    assign count_m1       = count_reg - CW'(1);
    assign count_p1       = count_reg + CW'(1);
    assign purge_left     = count_reg - removed_reg - CW'(1);
    assign in_ready       = (state_reg == ST_IDLE);

    // Hold a purge step while an earlier removed word cannot leave
    assign stall = b_vld_reg && (op_reg == ptq_pkg::OP_PURGE) && match
                   && (removed_reg != '0) && !emit_free;

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        req_next        = req_reg;
        count_next      = count_reg;
        rd_idx_next     = rd_idx_reg;
        rd_left_next    = rd_left_reg;
        b_vld_next      = b_vld_reg;
        b_idx_next      = b_idx_reg;
        pos_next        = pos_reg;
        removed_next    = removed_reg;
        res_next        = res_reg;
        res_status_next = res_status_reg;
        res_occ_next    = res_occ_reg;
        rd_en           = 1'b0;
        rd_addr         = rd_idx_reg;
        wr_en           = 1'b0;
        wr_addr         = b_idx_reg;
        wr_data         = rd_data;
        emit_valid      = 1'b0;
        emit_word       = '0;
        stop            = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                // Take a command word and set up the walk
                if (in_valid)
                begin
                    req_next     = in_word;
                    op_next      = ptq_pkg::op_t'(in_word.kind);
                    b_vld_next   = 1'b0;
                    removed_next = '0;
                    res_next     = '0;
                    res_occ_next = ptq_pkg::occ_bits(32'(count_reg));
                    rd_left_next = count_reg;
                    rd_idx_next  = '0;
                    pos_next     = '0;
                    unique case (ptq_pkg::op_t'(in_word.kind))
                        ptq_pkg::OP_INSERT:
                        begin
                            if (count_reg == FULL_CNT)
                            begin
                                res_status_next = ptq_pkg::STAT_FULL;
                                state_next      = ST_FIN;
                            end
                            else
                            begin
                                res_status_next = ptq_pkg::STAT_INSERTED;
                                pos_next        = count_reg;
                                rd_idx_next     = count_m1[IW-1:0];
                                state_next      = ST_RUN;
                            end
                        end
                        ptq_pkg::OP_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status_next = ptq_pkg::STAT_EMPTY;
                                res_occ_next    = '0;
                                state_next      = ST_FIN;
                            end
                            else
                            begin
                                res_status_next = ptq_pkg::STAT_REMOVED;
                                state_next      = ST_RUN;
                            end
                        end
                        ptq_pkg::OP_PURGE:
                        begin
                            res_status_next = ptq_pkg::STAT_EMPTY;
                            state_next      = ST_RUN;
                        end
                        ptq_pkg::OP_FLUSH:
                        begin
                            res_status_next = (count_reg != '0) ? ptq_pkg::STAT_REMOVED
                                                                : ptq_pkg::STAT_EMPTY;
                            res_occ_next    = '0;
                            count_next      = '0;
                            state_next      = ST_FIN;
                        end
                        default:
                        begin
                            state_next = ST_FIN;
                        end
                    endcase
                end
            end

            ST_RUN:
            begin
                if (!stall)
                begin
                    // Process the entry from the last issued read
                    if (b_vld_reg)
                    begin
                        unique case (op_reg)
                            ptq_pkg::OP_INSERT:
                            begin
                                wr_en   = 1'b1;
                                wr_addr = b_idx_reg + IW'(1);
                                if (rd_data.prio > req_reg.task_priority)
                                begin
                                    wr_data  = rd_data;
                                    pos_next = CW'(b_idx_reg);
                                end
                                else
                                begin
                                    wr_data = new_entry;
                                    stop    = 1'b1;
                                end
                            end
                            ptq_pkg::OP_POP:
                            begin
                                if (b_idx_reg == '0)
                                begin
                                    res_next = rd_data;
                                end
                                else
                                begin
                                    wr_en   = 1'b1;
                                    wr_addr = b_idx_reg - IW'(1);
                                end
                            end
                            ptq_pkg::OP_PURGE:
                            begin
                                if (match)
                                begin
                                    // Release the previous removed word, keep this one
                                    if (removed_reg != '0)
                                    begin
                                        emit_valid             = 1'b1;
                                        emit_word.status       = ptq_pkg::STAT_REMOVED;
                                        emit_word.out_tag      = res_reg.tag;
                                        emit_word.out_priority = res_reg.prio;
                                        emit_word.out_kind     = res_reg.kind;
                                        emit_word.last_of_run  = 1'b0;
                                        emit_word.occupancy    = res_occ_reg;
                                    end
                                    res_next        = rd_data;
                                    res_status_next = ptq_pkg::STAT_REMOVED;
                                    res_occ_next    = ptq_pkg::occ_bits(32'(purge_left));
                                    removed_next    = removed_reg + CW'(1);
                                end
                                else
                                begin
                                    // Compact the kept entry down
                                    wr_en    = 1'b1;
                                    wr_addr  = pos_reg[IW-1:0];
                                    pos_next = pos_reg + CW'(1);
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end

                    // Issue the next read
                    if ((rd_left_reg != '0) && !stop)
                    begin
                        rd_en        = 1'b1;
                        b_vld_next   = 1'b1;
                        b_idx_next   = rd_idx_reg;
                        rd_left_next = rd_left_reg - CW'(1);
                        rd_idx_next  = (op_reg == ptq_pkg::OP_INSERT) ? rd_idx_reg - IW'(1)
                                                                     : rd_idx_reg + IW'(1);
                    end
                    else
                    begin
                        b_vld_next = 1'b0;
                    end

                    // Close the walk
                    if (stop)
                    begin
                        count_next   = count_p1;
                        res_occ_next = ptq_pkg::occ_bits(32'(count_p1));
                        state_next   = ST_FIN;
                    end
                    else if (!b_vld_reg && (rd_left_reg == '0))
                    begin
                        unique case (op_reg)
                            ptq_pkg::OP_INSERT:
                            begin
                                wr_en        = 1'b1;
                                wr_addr      = pos_reg[IW-1:0];
                                wr_data      = new_entry;
                                count_next   = count_p1;
                                res_occ_next = ptq_pkg::occ_bits(32'(count_p1));
                            end
                            ptq_pkg::OP_POP:
                            begin
                                count_next   = count_m1;
                                res_occ_next = ptq_pkg::occ_bits(32'(count_m1));
                            end
                            ptq_pkg::OP_PURGE:
                            begin
                                count_next = pos_reg;
                            end
                            default:
                            begin
                            end
                        endcase
                        state_next = ST_FIN;
                    end
                end
            end

            ST_FIN:
            begin
                // Send the closing word
                if (emit_free)
                begin
                    emit_valid             = 1'b1;
                    emit_word.status       = res_status_reg;
                    emit_word.out_tag      = res_reg.tag;
                    emit_word.out_priority = res_reg.prio;
                    emit_word.out_kind     = res_reg.kind;
                    emit_word.last_of_run  = 1'b1;
                    emit_word.occupancy    = res_occ_reg;
                    state_next             = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            b_vld_reg   <= 1'b0;
            rd_left_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            b_vld_reg   <= b_vld_next;
            rd_left_reg <= rd_left_next;
        end
    end

    // Walk and result payload
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        req_reg        <= req_next;
        rd_idx_reg     <= rd_idx_next;
        b_idx_reg      <= b_idx_next;
        pos_reg        <= pos_next;
        removed_reg    <= removed_next;
        res_reg        <= res_next;
        res_status_reg <= res_status_next;
        res_occ_reg    <= res_occ_next;
    end

endmodule

`default_nettype wire

// File: hdl/priority_task_queue_core.sv
`timescale 1ns / 1ps
`default_nettype none
// Full insert, empty pop and flush go straight to their closing word after accept;
// insert, pop and purge walk the entry memory one entry per cycle while purge is not
// held by rsp (insert stops early at its sorted place).
// Throughput: one command in flight; the next is taken once the last word is loaded
// into the output register. The single-port read of the entry memory sets the walk
// rate; purge also waits on rsp.
// Reset clears the entry count and the control state; the entry memory is not cleared.

module priority_task_queue_core #(
    parameter int QUEUE_DEPTH = 16
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    ptq_stream_if.sink   cmd,
    ptq_stream_if.source rsp
);

    localparam int IW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic                 rd_en;
    logic [IW-1:0]        rd_addr;
    ptq_pkg::entry_t      rd_data;
    logic                 wr_en;
    logic [IW-1:0]        wr_addr;
    ptq_pkg::entry_t      wr_data;
    logic                 emit_valid;
    ptq_pkg::out_word_t   emit_word;
    logic                 emit_free;
    logic                 out_vld_reg, out_vld_next;
    ptq_pkg::out_word_t   out_word_reg;

    ptq_mem #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .IW          (IW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    ptq_seq #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .IW          (IW),
        .CW          (CW)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (cmd.valid),
        .in_ready   (cmd.ready),
        .in_word    (cmd.payload),
        .emit_valid (emit_valid),
        .emit_word  (emit_word),
        .emit_free  (emit_free),
        .rd_en      (rd_en),
        .rd_addr    (rd_addr),
        .rd_data    (rd_data),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data)
    );

    // Output register is free when empty or being taken
    assign emit_free = !out_vld_reg || rsp.ready;

    always_comb
    begin
        out_vld_next = out_vld_reg;
        if (emit_valid)
        begin
            out_vld_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else
        begin
            out_vld_reg <= out_vld_next;
        end
    end

    // Load the result word
    always_ff @(posedge clk)
    begin
        if (emit_valid)
        begin
            out_word_reg <= emit_word;
        end
    end

    assign rsp.valid   = out_vld_reg;
    assign rsp.payload = out_word_reg;

endmodule

`default_nettype wire

// File: hdl/ptq_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module ptq_checker #(
    parameter int QUEUE_DEPTH = 16
) (
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       cmd_valid,
    input wire logic       cmd_ready,
    input wire logic       rsp_valid,
    input wire logic       rsp_ready,
    input wire logic [1:0] status,
    input wire logic [4:0] occupancy,
    input wire logic [15:0] out_tag
);

    localparam logic [4:0] OCC_FULL = 5'(QUEUE_DEPTH);

    // A pending result word stays until taken
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("result word dropped while stalled");

    // A stalled result word keeps its content
    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> $stable(status) && $stable(occupancy) && $stable(out_tag))
        else $error("result word changed while stalled");

    // One command at a time: no command taken right after one is taken
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> !cmd_ready)
        else $error("command taken while another is in progress");

    // A full report only when the queue holds every slot
    a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == ptq_pkg::STAT_FULL) |-> occupancy == OCC_FULL)
        else $error("full status with wrong occupancy");

    // Occupancy never exceeds the depth (checked for depths up to 31)
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (QUEUE_DEPTH > 31) || (occupancy <= OCC_FULL))
        else $error("occupancy above queue depth");

endmodule

bind priority_task_queue_core ptq_checker #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
) u_ptq_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd.valid),
    .cmd_ready (cmd.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .status    (rsp.payload.status),
    .occupancy (rsp.payload.occupancy),
    .out_tag   (rsp.payload.out_tag)
);

`default_nettype wire
